// ===== hdl/bfdh_pkg.sv =====
// shared types, codes and constants for the double hashing bloom filter
package bfdh_pkg;

  localparam int KEY_W      = 32;
  localparam int FB_W       = 13;
  localparam int HC_W       = 5;
  localparam int CMD_W      = 2;
  localparam int ROT_RIGHT  = 17;
  localparam int MAX_PROBES = 30;
  localparam int MIN_BITS   = 64;
  localparam int WORD_W     = 32;
  localparam int BIT_SEL_W  = 5;

  localparam logic [FB_W-1:0] FB_RESET = FB_W'(4096);
  localparam logic [HC_W-1:0] HC_RESET = HC_W'(6);

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic REG_FILTER_BITS = 1'b0;
  localparam logic REG_HASH_COUNT  = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } bfdh_mod_stat_t;

  function automatic logic [KEY_W-1:0] rotr17(input logic [KEY_W-1:0] x);
    return {x[ROT_RIGHT-1:0], x[KEY_W-1:ROT_RIGHT]};
  endfunction

endpackage

// ===== hdl/bfdh_ram.sv =====
// generic single write port ram with registered read
module bfdh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/bfdh_mod.sv =====
// iterative remainder unit, one dividend bit per cycle
module bfdh_mod
  import bfdh_pkg::*;
#(
  parameter int DIV_W = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [KEY_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [DIV_W-1:0] remainder,
  output bfdh_mod_stat_t   stat
);

  localparam int CNT_W = $clog2(KEY_W);

  logic [KEY_W-1:0] a_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] rem_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;

  always_comb begin
    trial = {rem_r, a_r[KEY_W-1]};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      rem_nxt = diff[DIV_W-1:0];
    end else begin
      rem_nxt = trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(KEY_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      a_r   <= {a_r[KEY_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign remainder = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== hdl/bloom_filter_double_hash.sv =====
// bloom filter with double hashing over a word-wide bit store, top level
// flow: insert or query with k probes runs three bit-serial remainders, then a read and a check
//   per probe, then loads the result word; clear writes every store word; other words answer directly
// throughput: one word at a time, the next taken once the result word is loaded;
//   a stalled result word holds the block
// reset: synchronous active-low; a clearing pass over all STORE_WORDS words follows, config 4096/6
module bloom_filter_double_hash
  import bfdh_pkg::*;
#(
  parameter int FILTER_BITS = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] in_command,
  input  logic [KEY_W-1:0] in_key_hash,
  input  logic             in_key_is_empty,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_maybe_present,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [FB_W-1:0]  cfg_wdata
);

  localparam int STORE_WORDS = (FILTER_BITS + WORD_W - 1) / WORD_W;
  localparam int AW          = $clog2(STORE_WORDS);
  localparam int MW          = $clog2(FILTER_BITS + 1);
  localparam int CW          = (MW > FB_W) ? MW : FB_W;
  localparam logic [AW-1:0] LAST_WORD = AW'(STORE_WORDS - 1);
  localparam logic [CW-1:0] MIN_M     = CW'(MIN_BITS);
  localparam logic [CW-1:0] MAX_M     = CW'(FILTER_BITS);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MODH = 3'd2;
  localparam logic [2:0] S_MODD = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;
  localparam logic [2:0] S_MODC = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [FB_W-1:0]   fbits_r;
  logic [HC_W-1:0]   hcnt_r;
  logic              built_r, built_nxt;
  logic              clr_res_r, clr_res_nxt;
  logic              ans_r, ans_nxt;
  logic [HC_W-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [MW-1:0]     pos_r, pos_nxt;
  logic [MW-1:0]     dmod_r, dmod_nxt;
  logic [MW-1:0]     cmod_r, cmod_nxt;
  logic [KEY_W-1:0]  h_r, h_nxt;
  logic [KEY_W-1:0]  d_r;
  logic [CMD_W-1:0]  cmd_r;
  logic              out_valid_r;
  logic              out_mp_r;

  logic [CW-1:0]     m_c;
  logic [MW-1:0]     m_eff;
  logic [MW:0]       pos_sum;
  logic [MW:0]       pos_diff;
  logic [MW-1:0]     pos_adv;
  logic [MW-1:0]     pos_wrap;
  logic [KEY_W:0]    h_sum;
  logic [MW-1:0]     rem_inc;
  logic [MW-1:0]     cmod_c;

  logic              accept;
  logic              mod_start;
  logic [KEY_W-1:0]  mod_dividend;
  logic [MW-1:0]     mod_rem;
  bfdh_mod_stat_t    mod_stat;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     word_addr;
  logic [WORD_W-1:0] ram_rdata;
  logic              probe_bit;
  logic              out_free;

  // effective modulus: clamp between MIN_BITS and the store size, round down to a multiple of 8
  always_comb begin
    if (CW'(fbits_r) < MIN_M) begin
      m_c = MIN_M;
    end else if (CW'(fbits_r) > MAX_M) begin
      m_c = MAX_M;
    end else begin
      m_c = CW'(fbits_r);
    end
    m_eff = {m_c[MW-1:3], 3'b000};
  end

  assign pos_sum   = {1'b0, pos_r} + {1'b0, dmod_r};
  assign pos_diff  = pos_sum - {1'b0, m_eff};
  assign pos_adv   = (pos_sum >= {1'b0, m_eff}) ? pos_diff[MW-1:0] : pos_sum[MW-1:0];
  // a wrap of the 32-bit hash drops 2^32, so take its remainder back out
  assign h_sum     = {1'b0, h_r} + {1'b0, d_r};
  assign pos_wrap  = (pos_adv >= cmod_r) ? pos_adv - cmod_r : pos_adv + m_eff - cmod_r;
  // 2^32 mod m from (2^32 - 1) mod m
  assign rem_inc   = mod_rem + MW'(1);
  assign cmod_c    = (rem_inc == m_eff) ? '0 : rem_inc;
  assign word_addr = AW'(pos_r >> BIT_SEL_W);
  assign probe_bit = ram_rdata[pos_r[BIT_SEL_W-1:0]];

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt    = state_r;
    built_nxt    = built_r;
    clr_res_nxt  = clr_res_r;
    ans_nxt      = ans_r;
    cnt_nxt      = cnt_r;
    clr_nxt      = clr_r;
    pos_nxt      = pos_r;
    dmod_nxt     = dmod_r;
    cmod_nxt     = cmod_r;
    h_nxt        = h_r;
    mod_start    = 1'b0;
    mod_dividend = in_key_hash;
    ram_we       = 1'b0;
    ram_waddr    = word_addr;
    ram_wdata    = ram_rdata | (WORD_W'(1) << pos_r[BIT_SEL_W-1:0]);
    ram_re       = 1'b0;
    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == LAST_WORD) begin
          clr_nxt   = '0;
          state_nxt = clr_res_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cnt_nxt = hcnt_r;
          ans_nxt = 1'b0;
          h_nxt   = in_key_hash;
          priority if (in_command == CMD_CLEAR) begin
            built_nxt   = 1'b0;
            clr_res_nxt = 1'b1;
            clr_nxt     = '0;
            state_nxt   = S_CLR;
          end else if (in_command == CMD_INSERT) begin
            built_nxt = 1'b1;
            if (hcnt_r == '0) begin
              state_nxt = S_DONE;
            end else begin
              mod_start = 1'b1;
              state_nxt = S_MODH;
            end
          end else if (in_command == CMD_QUERY) begin
            if (in_key_is_empty || !built_r) begin
              state_nxt = S_DONE;
            end else if (hcnt_r > HC_W'(MAX_PROBES) || hcnt_r == '0) begin
              ans_nxt   = 1'b1;
              state_nxt = S_DONE;
            end else begin
              ans_nxt   = 1'b1;
              mod_start = 1'b1;
              state_nxt = S_MODH;
            end
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_MODH: begin
        mod_dividend = d_r;
        if (mod_stat.done) begin
          pos_nxt   = mod_rem;
          mod_start = 1'b1;
          state_nxt = S_MODD;
        end
      end
      S_MODD: begin
        mod_dividend = '1;
        if (mod_stat.done) begin
          dmod_nxt  = mod_rem;
          mod_start = 1'b1;
          state_nxt = S_MODC;
        end
      end
      S_MODC: begin
        if (mod_stat.done) begin
          cmod_nxt  = cmod_c;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (cmd_r == CMD_INSERT) begin
          ram_we = 1'b1;
        end
        if (cmd_r == CMD_QUERY && !probe_bit) begin
          ans_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else begin
          pos_nxt = h_sum[KEY_W] ? pos_wrap : pos_adv;
          h_nxt   = h_sum[KEY_W-1:0];
          cnt_nxt = cnt_r - 1'b1;
          state_nxt = (cnt_r == HC_W'(1)) ? S_DONE : S_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          clr_res_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      fbits_r     <= FB_RESET;
      hcnt_r      <= HC_RESET;
      built_r     <= 1'b0;
      clr_res_r   <= 1'b0;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      built_r   <= built_nxt;
      clr_res_r <= clr_res_nxt;
      clr_r     <= clr_nxt;
      cnt_r     <= cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FILTER_BITS: fbits_r <= cfg_wdata;
          REG_HASH_COUNT:  hcnt_r  <= cfg_wdata[HC_W-1:0];
          default:         fbits_r <= fbits_r;
        endcase
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ans_r  <= ans_nxt;
    pos_r  <= pos_nxt;
    dmod_r <= dmod_nxt;
    cmod_r <= cmod_nxt;
    h_r    <= h_nxt;
    if (accept) begin
      cmd_r <= in_command;
      d_r   <= rotr17(in_key_hash);
    end
    if (state_r == S_DONE && out_free) begin
      out_mp_r <= ans_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_maybe_present = out_mp_r;

  bfdh_mod #(
    .DIV_W(MW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (m_eff),
    .remainder(mod_rem),
    .stat     (mod_stat)
  );

  bfdh_ram #(
    .WIDTH(WORD_W),
    .DEPTH(STORE_WORDS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(word_addr),
    .rdata(ram_rdata)
  );

endmodule

// ===== hdl/bfdh_checker.sv =====
// port-level checks for the bloom filter and their binding to the top level
module bfdh_checker
  import bfdh_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic [CMD_W-1:0] in_command,
  input logic             in_key_is_empty,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_maybe_present
);

  logic last_query_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_query_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      last_query_r <= (in_command == CMD_QUERY) && !in_key_is_empty;
    end
  end

  // reset starts the clearing pass with nothing offered on either side
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("block ready or result shown right after reset");

  // one word in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted while the previous one is still in work");

  // only a non-empty query can answer maybe
  a_maybe_only_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (!out_maybe_present || last_query_r))
    else $error("maybe answer for a word that is no non-empty query");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_maybe_present))
    else $error("stalled result word dropped or changed");

endmodule

bind bloom_filter_double_hash bfdh_checker u_bfdh_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_command       (in_command),
  .in_key_is_empty  (in_key_is_empty),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_maybe_present(out_maybe_present)
);

// ===== verif/bfdh_checker.sv =====
// answer checker for the bloom filter: tracks the filter contents, predicts each answer, compares
module bfdh_answer_checker
  import bfdh_pkg::*;
#(
  parameter int FILTER_BITS = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [CMD_W-1:0] in_command,
  input  logic [KEY_W-1:0] in_key_hash,
  input  logic             in_key_is_empty,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic             out_maybe_present,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [FB_W-1:0]  cfg_wdata,
  output int               fail_count,
  output int               pending
);

  bit            store_bits [FILTER_BITS];
  bit            built;
  bit [FB_W-1:0] bits_cfg;
  bit [HC_W-1:0] probes_cfg;
  bit            answers_due [$];

  function automatic bit filter_answer(logic [CMD_W-1:0] cmd, bit [KEY_W-1:0] key, bit empty);
    int unsigned     m;
    bit [KEY_W-1:0]  pos_hash;
    bit [KEY_W-1:0]  step;
    bit              hit;
    m = bits_cfg;
    if (m < MIN_BITS) m = MIN_BITS;
    if (m > FILTER_BITS) m = FILTER_BITS;
    m = m & 32'hFFFF_FFF8;
    if (m == 0) m = 8;
    pos_hash = key;
    step = (key >> ROT_RIGHT) | (key << (KEY_W - ROT_RIGHT));
    hit = 1'b0;
    case (cmd)
      CMD_CLEAR: begin
        foreach (store_bits[i]) store_bits[i] = 1'b0;
        built = 1'b0;
      end
      CMD_INSERT: begin
        for (int j = 0; j < probes_cfg; j++) begin
          store_bits[pos_hash % m] = 1'b1;
          pos_hash += step;
        end
        built = 1'b1;
      end
      CMD_QUERY: begin
        if (!empty && built) begin
          hit = 1'b1;
          if (probes_cfg <= MAX_PROBES) begin
            for (int j = 0; j < probes_cfg; j++) begin
              if (!store_bits[pos_hash % m]) begin
                hit = 1'b0;
                break;
              end
              pos_hash += step;
            end
          end
        end
      end
      default: ;
    endcase
    return hit;
  endfunction

  always @(posedge clk) begin
    bit expected;
    if (!rst_n) begin
      foreach (store_bits[i]) store_bits[i] = 1'b0;
      built = 1'b0;
      bits_cfg = FB_RESET;
      probes_cfg = HC_RESET;
      answers_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FILTER_BITS) bits_cfg = cfg_wdata;
        else probes_cfg = cfg_wdata[HC_W-1:0];
      end
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          $error("maybe_present: unexpected result word, actual %0d", out_maybe_present);
          fail_count++;
        end else begin
          expected = answers_due.pop_front();
          if (out_maybe_present !== expected) begin
            $error("maybe_present mismatch: expected %0d, actual %0d",
                   expected, out_maybe_present);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        answers_due.push_back(filter_answer(in_command, in_key_hash, in_key_is_empty));
    end
    pending = answers_due.size();
  end

endmodule

// ===== verif/tb_bloom_filter_double_hash.sv =====
// testbench top for the bloom filter: clock, reset, stimulus, watchdog and verdict
module tb_bloom_filter_double_hash
  import bfdh_pkg::*;
;

  localparam int FILTER_BITS = 4096;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASES      = 12;
  localparam int PHASE_WORDS = 120;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [CMD_W-1:0] in_command;
  logic [KEY_W-1:0] in_key_hash;
  logic             in_key_is_empty;
  logic             out_valid;
  logic             out_ready;
  logic             out_maybe_present;
  logic             cfg_we;
  logic             cfg_index;
  logic [FB_W-1:0]  cfg_wdata;

  int              fail_count;
  int              pending;
  int              quiet_cycles;
  int              idle_pct;
  int              stall_pct;
  bit              calm;
  bit [KEY_W-1:0]  key_pool [$];

  bloom_filter_double_hash #(.FILTER_BITS(FILTER_BITS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_key_hash      (in_key_hash),
    .in_key_is_empty  (in_key_is_empty),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_maybe_present(out_maybe_present),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  bfdh_answer_checker #(.FILTER_BITS(FILTER_BITS)) answer_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_key_hash      (in_key_hash),
    .in_key_is_empty  (in_key_is_empty),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_maybe_present(out_maybe_present),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(1, 100) <= stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_word(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key, logic empty);
    in_command      <= cmd;
    in_key_hash     <= key;
    in_key_is_empty <= empty;
    in_valid        <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (!calm && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  endtask

  // hold off until every answer is back and the block takes words again
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0 || !in_ready);
  endtask

  task automatic set_config(logic [FB_W-1:0] fb, logic [FB_W-1:0] hc);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FILTER_BITS;
    cfg_wdata <= fb;
    @(negedge clk);
    cfg_index <= REG_HASH_COUNT;
    cfg_wdata <= hc;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned     r;
    logic [FB_W-1:0] fb;
    logic [FB_W-1:0] hc;
    logic [KEY_W-1:0] key;
    in_valid        = 1'b0;
    in_command      = CMD_CLEAR;
    in_key_hash     = '0;
    in_key_is_empty = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_FILTER_BITS;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    calm            = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    drain();

    // directed words on reset settings
    send_word(CMD_QUERY,  32'h1234_5678, 1'b0);
    send_word(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1);
    send_word(CMD_INSERT, 32'h0000_0000, 1'b0);
    send_word(CMD_INSERT, 32'hFFFF_FFFF, 1'b0);
    send_word(CMD_INSERT, 32'hDEAD_BEEF, 1'b1);
    send_word(CMD_QUERY,  32'h0000_0000, 1'b0);
    send_word(CMD_QUERY,  32'hFFFF_FFFF, 1'b0);
    send_word(CMD_QUERY,  32'hDEAD_BEEF, 1'b0);
    send_word(CMD_QUERY,  32'hDEAD_BEEF, 1'b1);
    send_word(CMD_QUERY,  32'hA5A5_A5A5, 1'b0);
    send_word(CMD_CLEAR,  32'h0000_0000, 1'b0);
    send_word(CMD_QUERY,  32'h0000_0000, 1'b0);
    send_word(CMD_INSERT, 32'h8000_0001, 1'b0);
    send_word(CMD_QUERY,  32'h8000_0001, 1'b0);
    drain();
    set_config(13'd64, 13'd0);
    send_word(CMD_INSERT, 32'h0000_0005, 1'b0);
    send_word(CMD_QUERY,  32'h0000_0077, 1'b0);
    send_word(CMD_QUERY,  32'h0000_0077, 1'b1);
    drain();
    set_config(13'd8191, 13'd31);
    send_word(CMD_INSERT, 32'h1357_9BDF, 1'b0);
    send_word(CMD_QUERY,  32'h2468_ACE0, 1'b0);
    drain();
    set_config(13'd0, 13'h1FFE);
    send_word(CMD_QUERY,  32'h1357_9BDF, 1'b0);
    send_word(CMD_QUERY,  32'h5555_AAAA, 1'b0);
    drain();
    set_config(13'd100, 13'd1);
    send_word(CMD_QUERY,  32'h0000_0005, 1'b0);
    send_word(CMD_INSERT, 32'h7FFF_FFFF, 1'b0);
    send_word(CMD_QUERY,  32'h7FFF_FFFF, 1'b0);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 4))
        0: fb = 13'd64;
        1: fb = 13'd4096;
        2: fb = FB_W'($urandom_range(0, 8191));
        default: fb = FB_W'(8 * $urandom_range(8, 64));
      endcase
      r = $urandom_range(0, 9);
      if (r == 0) hc = 13'd0;
      else if (r == 1) hc = 13'd30;
      else if (r == 2) hc = 13'd31;
      else hc = FB_W'($urandom_range(1, 8));
      hc[FB_W-1:HC_W] = (FB_W-HC_W)'($urandom);
      set_config(fb, hc);
      calm = (phase == PHASES - 1);
      r = $urandom_range(0, 2);
      idle_pct = (r == 0) ? 0 : (r == 1) ? 20 : 50;
      r = $urandom_range(0, 2);
      stall_pct = (r == 0) ? 0 : (r == 1) ? 20 : 50;
      if (phase % 4 == 0) send_word(CMD_CLEAR, $urandom, 1'($urandom_range(0, 1)));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        r = $urandom_range(1, 100);
        if (key_pool.size() != 0 && $urandom_range(0, 9) < 6)
          key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else
          key = $urandom;
        if (r <= 2) begin
          send_word(CMD_UNUSED, key, 1'($urandom_range(0, 1)));
        end else if (r <= 5) begin
          send_word(CMD_CLEAR, key, 1'($urandom_range(0, 1)));
          key_pool.delete();
        end else if (r <= 45) begin
          key = $urandom;
          send_word(CMD_INSERT, key, $urandom_range(1, 10) == 1);
          key_pool.push_back(key);
          if (key_pool.size() > 64) void'(key_pool.pop_front());
        end else begin
          send_word(CMD_QUERY, key, $urandom_range(1, 10) == 1);
        end
      end
      drain();
    end

    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bfdh_pkg.sv
hdl/bfdh_ram.sv
hdl/bfdh_mod.sv
hdl/bloom_filter_double_hash.sv
hdl/bfdh_checker.sv
verif/bfdh_checker.sv
verif/tb_bloom_filter_double_hash.sv
